// File: rtl/base62_bit_stream_encoder_top_defines.svh
// Assertion macros for the base62 bit-stream encoder.
`ifndef BASE62_BIT_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE62_BIT_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define B62E_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("b62enc assertion failed");
`define B62E_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("b62enc forbidden condition seen");
`else
`define B62E_ASSERT(lbl, prop)
`define B62E_NEVER(lbl, expr)
`endif

`endif

// File: rtl/b62enc_pkg.sv
// Shared types, constants and character mapping for the base62 encoder.
`default_nettype none

package b62enc_pkg;

	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned GROUP_W = 6;
	localparam int unsigned TAIL_W  = 5;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned MAX_OUT = 3;

	localparam logic [GROUP_W-1:0] IDX_ESC5  = 6'd61;
	localparam logic [GROUP_W-1:0] IDX_ESC4  = 6'd60;
	localparam logic [GROUP_W-1:0] IDX_LOWER = 6'd26;
	localparam logic [GROUP_W-1:0] IDX_DIGIT = 6'd52;

	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;

	typedef struct packed {
		logic [CHAR_W-1:0] code_char;
		logic              run_end;
		logic              message_end;
	} entry_t;

	typedef struct packed {
		entry_t [MAX_OUT-1:0] ent;    // ent[0] goes out first
		logic   [1:0]         cnt;    // 1 to 3
		logic   [CNT_W-1:0]   held;   // bits left over, 0 to 5
		logic   [TAIL_W-1:0]  store;  // left-over bits, right-aligned
	} split_t;

	// six-bit group to alphabet index, with the escapes for high groups
	function automatic logic [GROUP_W-1:0] group_idx(input logic [GROUP_W-1:0] g);
		logic [GROUP_W-1:0] r;
		if (g[5:1] == 5'h1f) begin
			r = IDX_ESC5;
		end else if (g[5:2] == 4'hf) begin
			r = IDX_ESC4;
		end else begin
			r = g;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] idx_char(input logic [GROUP_W-1:0] i);
		logic [CHAR_W-1:0] r;
		if (i < IDX_LOWER) begin
			r = ASCII_UPPER_A + {1'b0, i};
		end else if (i < IDX_DIGIT) begin
			r = ASCII_LOWER_A + {1'b0, i - IDX_LOWER};
		end else begin
			r = ASCII_ZERO + {1'b0, i - IDX_DIGIT};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/b62enc_split.sv
// Splits held bits plus one byte into up to three output characters.
`default_nettype none

module b62enc_split (
	input  wire logic [b62enc_pkg::TAIL_W-1:0] held_store,
	input  wire logic [b62enc_pkg::CNT_W-1:0]  held_cnt,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          final_byte,
	output b62enc_pkg::split_t                 res
);

	logic [12:0] store;
	logic [3:0]  n0;
	logic [3:0]  n1;
	logic [3:0]  n2;
	logic [3:0]  d1;
	logic [3:0]  d2;
	logic [2:0]  sh1;
	logic [1:0]  sh2;
	logic [5:0]  g1;
	logic [5:0]  g2;
	logic [5:0]  i1;
	logic [5:0]  i2;
	logic        two;
	logic        tail;
	logic [5:0]  mask;
	logic [4:0]  rem;
	logic [6:0]  c1;
	logic [6:0]  c2;
	logic [6:0]  ct;
	logic [1:0]  cnt;

	always_comb begin
		store = {held_store, data_byte};
		n0    = {1'b0, held_cnt} + 4'd8;

		d1  = n0 - 4'd6;
		sh1 = d1[2:0];
		g1  = 6'((store >> sh1) & 13'h3f);
		i1  = b62enc_pkg::group_idx(g1);
		// escapes use five bits, plain groups six
		n1  = (i1 >= b62enc_pkg::IDX_ESC4) ? n0 - 4'd5 : n0 - 4'd6;

		two = (n1 >= 4'd6);
		d2  = n1 - 4'd6;
		sh2 = d2[1:0];
		g2  = 6'((store >> sh2) & 13'h3f);
		i2  = b62enc_pkg::group_idx(g2);
		if (two) begin
			n2 = (i2 >= b62enc_pkg::IDX_ESC4) ? n1 - 4'd5 : n1 - 4'd6;
		end else begin
			n2 = n1;
		end

		mask = (6'd1 << n2[2:0]) - 6'd1;
		rem  = store[4:0] & mask[4:0];
		tail = final_byte && (n2 != 4'd0);

		c1 = b62enc_pkg::idx_char(i1);
		c2 = b62enc_pkg::idx_char(i2);
		ct = b62enc_pkg::idx_char({1'b0, rem});

		cnt = 2'd1 + {1'b0, two} + {1'b0, tail};

		res.ent[0].code_char = c1;
		res.ent[1].code_char = two ? c2 : ct;
		res.ent[2].code_char = ct;
		res.ent[0].run_end   = (cnt == 2'd1);
		res.ent[1].run_end   = (cnt == 2'd2);
		res.ent[2].run_end   = (cnt == 2'd3);
		res.ent[0].message_end = final_byte && (cnt == 2'd1);
		res.ent[1].message_end = final_byte && (cnt == 2'd2);
		res.ent[2].message_end = final_byte && (cnt == 2'd3);
		res.cnt   = cnt;
		res.held  = final_byte ? '0 : n2[2:0];
		res.store = final_byte ? '0 : rem;
	end

endmodule

`default_nettype wire

// File: rtl/base62_bit_stream_encoder_top.sv
// Top level of the base62 bit-stream encoder: input register, splitter, result queue.
//
//  channel | direction | tdata                          | tuser   | tlast
//  s_*     | in        | [7:0] data_byte                | -       | final_byte
//  m_*     | out       | [6:0] code_char, [7] zero      | run_end | message_end
//
// A byte request is held in the input register, then split in one pass
// into one to three characters that load a three-entry queue feeding the output.
// The queue sends one character a cycle while m_tready is high; a byte yields
// one or two characters, up to three for a final byte. The next byte is taken
// while the last character of the previous one waits at the output.
// An output stall holds the queue; once the input register is also full, s_tready drops.
// Reset clears the held bits, the input valid flag and the queue count.
`default_nettype none

module base62_bit_stream_encoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [6:0] code_char, [7] zero
	output logic            m_tuser,   // [0] run_end
	output logic            m_tlast
);

`include "base62_bit_stream_encoder_top_defines.svh"

	logic                                   valid_s1;
	logic [7:0]                             byte_s1;
	logic                                   final_s1;
	logic [b62enc_pkg::TAIL_W-1:0]          store_q;
	logic [b62enc_pkg::CNT_W-1:0]           held_q;
	b62enc_pkg::entry_t [b62enc_pkg::MAX_OUT-1:0] ent_q;
	logic [1:0]                             cnt_q;
	b62enc_pkg::split_t                     split;
	logic                                   take;
	logic                                   load;

	b62enc_split u_split (
		.held_store (store_q),
		.held_cnt   (held_q),
		.data_byte  (byte_s1),
		.final_byte (final_s1),
		.res        (split)
	);

	assign take     = m_tvalid && m_tready;
	// queue refills when empty or as its last character leaves
	assign load     = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && take));
	assign s_tready = !valid_s1 || load;

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {1'b0, ent_q[0].code_char};
	assign m_tuser  = ent_q[0].run_end;
	assign m_tlast  = ent_q[0].message_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			held_q   <= '0;
			store_q  <= '0;
			cnt_q    <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				held_q  <= split.held;
				store_q <= split.store;
				cnt_q   <= split.cnt;
			end else if (take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
		if (load) begin
			ent_q <= split.ent;
		end else if (take) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	`B62E_NEVER(a_held_range, held_q > 3'd5)
	`B62E_ASSERT(a_load_nonempty, load |-> (split.cnt != 2'd0))
	`B62E_ASSERT(a_final_clears, (load && final_s1) |=> (held_q == 3'd0))
	`B62E_ASSERT(a_empty_accepts, (cnt_q == 2'd0) |-> s_tready)

endmodule

`default_nettype wire
